// File: design/bfs_er_pkg.sv
// Shared types, constants and helper functions for the BFS edge relaxation block.
package bfs_er_pkg;

    localparam int TILE_W     = 8;
    localparam int LOCAL_W    = 20;
    localparam int DEPTH_W    = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ROOT_W     = 20;

    localparam int                 VERTEX_BITS_DEF = 20;
    localparam int                 LOCAL_BITS_DEF  = 12;
    localparam logic [DEPTH_W-1:0] UNREACHED_DEF   = 8'd255;

    localparam logic [DEPTH_W-1:0] ROOT_DEPTH = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMMETRIC   = 2'd0,
        CFG_TILE_OFFSET = 2'd1,
        CFG_ROOT        = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] update_count;
        logic               dst_tile_active;
        logic               src_tile_active;
        logic [TILE_W-1:0]  tile_row;
        logic [TILE_W-1:0]  tile_col;
    } t_result;

    // True when the vertex at depth lt may take depth lf + 1.
    function automatic logic can_relax(
        input logic [DEPTH_W-1:0] lf,
        input logic [DEPTH_W-1:0] lt,
        input logic [DEPTH_W-1:0] unr
    );
        logic [DEPTH_W:0] inc;
        inc = {1'b0, lf} + {{DEPTH_W{1'b0}}, 1'b1};
        return (lf != unr) && (inc < {1'b0, unr}) &&
               ((lt == unr) || ({1'b0, lt} > inc));
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
        return (x == {COUNT_W{1'b1}}) ? x : x + {{(COUNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// File: design/bfs_er_edge_if.sv
// Edge request channel: valid/ready handshake with one graph edge as payload.
interface bfs_er_edge_if;
    logic                            valid;
    logic                            ready;
    logic [bfs_er_pkg::TILE_W-1:0]   src_tile;
    logic [bfs_er_pkg::TILE_W-1:0]   dst_tile;
    logic [bfs_er_pkg::LOCAL_W-1:0]  src_local;
    logic [bfs_er_pkg::LOCAL_W-1:0]  dst_local;
    logic                            last_in_tile;

    modport source (
        output valid, src_tile, dst_tile, src_local, dst_local, last_in_tile,
        input  ready
    );
    modport sink (
        input  valid, src_tile, dst_tile, src_local, dst_local, last_in_tile,
        output ready
    );
endinterface

// File: design/bfs_er_result_if.sv
// Tile result channel: valid/ready handshake with one per-tile report as payload.
interface bfs_er_result_if;
    logic                            valid;
    logic                            ready;
    logic [bfs_er_pkg::COUNT_W-1:0]  update_count;
    logic                            dst_tile_active;
    logic                            src_tile_active;
    logic [bfs_er_pkg::TILE_W-1:0]   tile_row;
    logic [bfs_er_pkg::TILE_W-1:0]   tile_col;

    modport source (
        output valid, update_count, dst_tile_active, src_tile_active, tile_row, tile_col,
        input  ready
    );
    modport sink (
        input  valid, update_count, dst_tile_active, src_tile_active, tile_row, tile_col,
        output ready
    );
endinterface

// File: design/bfs_edge_relaxation.sv
// A tile report is registered in the result queue after the compare stage sees its last edge.
// Throughput: one edge per cycle while i_edge.ready is high, set by the read-modify-write of
// the depth memory (two read ports, one write port, last write forwarded to the next edge).
// Reset, and every root_vertex write, start a clearing pass over every entry of the depth
// memory; no edge is accepted until it ends, config writes still are.
// A three-entry result queue holds reports while the sink stalls.
module bfs_edge_relaxation #(
    parameter int                                  VERTEX_BITS = bfs_er_pkg::VERTEX_BITS_DEF,
    parameter int                                  LOCAL_BITS  = bfs_er_pkg::LOCAL_BITS_DEF,
    parameter logic [bfs_er_pkg::DEPTH_W-1:0]      UNREACHED   = bfs_er_pkg::UNREACHED_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    bfs_er_edge_if.sink                            i_edge,
    bfs_er_result_if.source                        o_result,
    input  logic                                   i_cfg_we,
    input  logic [bfs_er_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bfs_er_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DW = bfs_er_pkg::DEPTH_W;
    localparam int CW = bfs_er_pkg::COUNT_W;
    localparam int TW = bfs_er_pkg::TILE_W;

    // configuration
    logic                          r_sym;
    logic                          r_tofs;
    logic [bfs_er_pkg::ROOT_W-1:0] r_root;
    logic                          cfg_root_wr;

    // clearing pass
    logic                   r_clearing;
    logic [VERTEX_BITS-1:0] r_clr_addr;
    logic [VERTEX_BITS-1:0] root_idx;

    // depth memory
    logic [DW-1:0]          r_depth_mem [0:(2**VERTEX_BITS)-1];
    logic [DW-1:0]          r_rd0;
    logic [DW-1:0]          r_rd1;
    logic                   mem_we;
    logic [VERTEX_BITS-1:0] mem_waddr;
    logic [DW-1:0]          mem_wdata;

    // request side
    logic                   edge_acc;
    logic [VERTEX_BITS-1:0] in_v0;
    logic [VERTEX_BITS-1:0] in_v1;

    // compare stage
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [VERTEX_BITS-1:0] r_s1_v0;
    logic [VERTEX_BITS-1:0] r_s1_v1;
    logic [TW-1:0]          r_s1_st;
    logic [TW-1:0]          r_s1_dt;
    logic [DW-1:0]          l0;
    logic [DW-1:0]          l1;
    logic                   fwd_ok;
    logic                   rev_ok;
    logic                   s1_we;
    logic [VERTEX_BITS-1:0] s1_waddr;
    logic [DW-1:0]          s1_wdata;

    // last write, forwarded to the edge read at the same edge
    logic                   r_fw_valid;
    logic [VERTEX_BITS-1:0] r_fw_addr;
    logic [DW-1:0]          r_fw_data;

    // counters and report
    logic [CW-1:0]          r_fwd_cnt;
    logic [CW-1:0]          r_rev_cnt;
    logic [CW-1:0]          n_fwd_cnt;
    logic [CW-1:0]          n_rev_cnt;
    logic [CW:0]            cnt_sum;
    bfs_er_pkg::t_result    s1_result;

    // result queue
    bfs_er_pkg::t_result    r_q [0:2];
    logic [1:0]             r_wr_ptr;
    logic [1:0]             r_rd_ptr;
    logic [1:0]             r_cnt;
    logic                   q_push;
    logic                   q_pop;

    assign cfg_root_wr = i_cfg_we && (i_cfg_index == bfs_er_pkg::CFG_ROOT);
    assign root_idx    = VERTEX_BITS'(r_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym  <= 1'b0;
            r_tofs <= 1'b1;
            r_root <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfs_er_pkg::CFG_SYMMETRIC:   r_sym  <= i_cfg_data[0];
                bfs_er_pkg::CFG_TILE_OFFSET: r_tofs <= i_cfg_data[0];
                bfs_er_pkg::CFG_ROOT:        r_root <= i_cfg_data[bfs_er_pkg::ROOT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sweep every entry; restart whenever a new root arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (cfg_root_wr) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {VERTEX_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Accept unless clearing, or the queue could not take a report from both stages.
    assign i_edge.ready = !r_clearing && (r_cnt != 2'd3) &&
                          !((r_cnt == 2'd2) && r_s1_valid && r_s1_last);
    assign edge_acc     = i_edge.valid && i_edge.ready;

    always_comb begin
        in_v0 = VERTEX_BITS'(i_edge.src_local);
        in_v1 = VERTEX_BITS'(i_edge.dst_local);
        if (r_tofs) begin
            in_v0 = in_v0 + (VERTEX_BITS'(i_edge.src_tile) << LOCAL_BITS);
            in_v1 = in_v1 + (VERTEX_BITS'(i_edge.dst_tile) << LOCAL_BITS);
        end
    end

    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = (r_clr_addr == root_idx) ? bfs_er_pkg::ROOT_DEPTH : UNREACHED;
        end else begin
            mem_we    = s1_we;
            mem_waddr = s1_waddr;
            mem_wdata = s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_depth_mem[mem_waddr] <= mem_wdata;
        end
        if (edge_acc) begin
            r_rd0 <= r_depth_mem[in_v0];
            r_rd1 <= r_depth_mem[in_v1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= edge_acc;
            r_fw_valid <= s1_we;
        end
        if (edge_acc) begin
            r_s1_last <= i_edge.last_in_tile;
            r_s1_v0   <= in_v0;
            r_s1_v1   <= in_v1;
            r_s1_st   <= i_edge.src_tile;
            r_s1_dt   <= i_edge.dst_tile;
        end
        r_fw_addr <= s1_waddr;
        r_fw_data <= s1_wdata;
    end

    // The memory read missed the write made at the same edge: take it from the bypass.
    assign l0 = (r_fw_valid && (r_fw_addr == r_s1_v0)) ? r_fw_data : r_rd0;
    assign l1 = (r_fw_valid && (r_fw_addr == r_s1_v1)) ? r_fw_data : r_rd1;

    always_comb begin
        fwd_ok   = bfs_er_pkg::can_relax(l0, l1, UNREACHED);
        rev_ok   = !fwd_ok && r_sym && bfs_er_pkg::can_relax(l1, l0, UNREACHED);
        s1_we    = r_s1_valid && (fwd_ok || rev_ok);
        s1_waddr = fwd_ok ? r_s1_v1 : r_s1_v0;
        s1_wdata = (fwd_ok ? l0 : l1) + {{(DW-1){1'b0}}, 1'b1};

        n_fwd_cnt = (r_s1_valid && fwd_ok) ? bfs_er_pkg::sat_inc(r_fwd_cnt) : r_fwd_cnt;
        n_rev_cnt = (r_s1_valid && rev_ok) ? bfs_er_pkg::sat_inc(r_rev_cnt) : r_rev_cnt;
        cnt_sum   = {1'b0, n_fwd_cnt} + {1'b0, n_rev_cnt};

        s1_result.update_count    = cnt_sum[CW] ? {CW{1'b1}} : cnt_sum[CW-1:0];
        s1_result.dst_tile_active = (n_fwd_cnt != '0);
        s1_result.src_tile_active = (n_rev_cnt != '0);
        s1_result.tile_row        = r_s1_st;
        s1_result.tile_col        = r_s1_dt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_root_wr) begin
            r_fwd_cnt <= '0;
            r_rev_cnt <= '0;
        end else if (r_s1_valid) begin
            // drop the tile pair counts once they are reported
            r_fwd_cnt <= r_s1_last ? '0 : n_fwd_cnt;
            r_rev_cnt <= r_s1_last ? '0 : n_rev_cnt;
        end
    end

    assign q_push = r_s1_valid && r_s1_last;
    assign q_pop  = o_result.valid && o_result.ready;

    // Pointers wrap after the third entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 2'd0;
        end else begin
            if (q_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'd2) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (q_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'd2) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, q_push} - {1'b0, q_pop};
        end
        if (q_push) begin
            r_q[r_wr_ptr] <= s1_result;
        end
    end

    assign o_result.valid           = (r_cnt != 2'd0);
    assign o_result.update_count    = r_q[r_rd_ptr].update_count;
    assign o_result.dst_tile_active = r_q[r_rd_ptr].dst_tile_active;
    assign o_result.src_tile_active = r_q[r_rd_ptr].src_tile_active;
    assign o_result.tile_row        = r_q[r_rd_ptr].tile_row;
    assign o_result.tile_col        = r_q[r_rd_ptr].tile_col;

`ifndef ASSERT_OFF
    a_no_edge_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !edge_acc)
        else $error("edge accepted during clearing pass");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd3) |-> !q_push)
        else $error("result queue overrun");

    a_report_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> (r_cnt != 2'd0))
        else $error("tile report lost");

    a_self_loop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_v0 == r_s1_v1)) |-> !s1_we)
        else $error("self loop updated depth");

    a_bypass_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_we |=> (r_fw_valid && (r_fw_addr == $past(s1_waddr))))
        else $error("bypass missed a depth write");
`endif

endmodule
